/* rtl/bsa_pkg.sv */
// Shared constants, types and helpers of the bitmap slot allocator.
// No dependencies; imported by the allocator top level.
package bsa_pkg;

    localparam int MAP_WORDS = 32;                      // words in the free map
    localparam int WORD_W    = 32;                      // slots per word
    localparam int BIT_W     = $clog2(WORD_W);          // bit index within a word
    localparam int WORD_AW   = $clog2(MAP_WORDS);       // word index
    localparam int SCAN_W    = WORD_AW + 1;             // start word, may reach MAP_WORDS
    localparam int SLOT_W    = WORD_AW + BIT_W;         // slot number
    localparam int KEY_W     = 32;
    localparam int KEY_OUT_W = 12;
    localparam int KEY_LIMIT = MAP_WORDS * WORD_W * 4;  // first rejected byte key

    localparam logic [WORD_W-1:0] WORD0_RESET = WORD_W'(32'h0000_00E0);
    localparam logic [WORD_W-1:0] WORDN_RESET = '1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_FREE    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CHK  = 2'b10
    } state_t;

    // Contents a word holds before it is ever written.
    function automatic logic [WORD_W-1:0] reset_word(input logic [WORD_AW-1:0] idx);
        reset_word = (idx == '0) ? WORD0_RESET : WORDN_RESET;
    endfunction

    // Index of the lowest set bit; top index when the word is empty.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        lowest_set = BIT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                lowest_set = BIT_W'(i);
            end
        end
    endfunction

endpackage

/* rtl/bsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/bitmap_slot_allocator.sv */
// Bitmap slot allocator: 1024 slots in a 32-word free map, a set bit marks a free slot.
// An input beat with tuser[0]=0 allocates the lowest free slot at or above the start word
// and returns slot*4; tuser[0]=1 frees the slot key/4 (keys of 4096 or more fail) and
// moves the start word there. Every input beat yields one result beat, status in tuser[0].
// Timing: the result is loaded in the check state, for a free at once and for an allocate
// when the scan stops, but only once the output register is free; the block then returns
// to idle for the next beat. An allocate passes each empty word in turn, bounded by the
// single read port of the map RAM, read one word per cycle. A new beat is taken in the
// cycle after a result is loaded, even if that result has not yet been taken. The map
// needs no clearing pass after reset. Depends on bsa_pkg and bsa_ram.
module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] slot_key, [15:12] zero
    output logic [0:0]  m_tuser    // [0] status
);

    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   scan_word_reg, scan_word_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;
    logic                act_reg;
    logic                key_ok_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_status_reg, out_status_next;
    logic [KEY_OUT_W-1:0] out_key_reg, out_key_next;

    logic                accept;
    logic                out_free;
    logic                rd_en;
    logic [WORD_AW-1:0]  rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_AW-1:0]  cur_idx;
    logic [WORD_W-1:0]   map_word;
    logic [BIT_W-1:0]    low_bit;
    logic                scan_end;
    logic [SCAN_W-1:0]   scan_inc;
    logic [SLOT_W+1:0]   alloc_key;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_status_reg;
    assign m_tdata    = 16'(out_key_reg);

    bsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cur_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Words never written read as their reset contents.
    assign cur_idx   = (act_reg == ACT_FREE) ? slot_reg[SLOT_W-1:BIT_W]
                                             : scan_word_reg[WORD_AW-1:0];
    assign map_word  = valid_reg[cur_idx] ? rd_data : reset_word(cur_idx);
    assign low_bit   = lowest_set(map_word);
    assign scan_end  = (scan_word_reg == SCAN_W'(MAP_WORDS));
    assign scan_inc  = scan_word_reg + SCAN_W'(1);
    assign alloc_key = {scan_word_reg[WORD_AW-1:0], low_bit, 2'b00};

    always_comb begin
        state_next      = state_reg;
        scan_word_next  = scan_word_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_word_reg[WORD_AW-1:0];
        wr_en           = 1'b0;
        wr_data         = map_word;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rd_en      = 1'b1;
                    rd_addr    = (s_tuser[0] == ACT_FREE) ? s_tdata[SLOT_W+1:BIT_W+2]
                                                          : scan_word_reg[WORD_AW-1:0];
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (act_reg == ACT_FREE) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_key_next    = '0;
                        out_status_next = key_ok_reg ? STATUS_OK : STATUS_FAIL;
                        state_next      = S_IDLE;
                        if (key_ok_reg) begin
                            wr_en          = 1'b1;
                            wr_data        = map_word | (WORD_W'(1) << slot_reg[BIT_W-1:0]);
                            scan_word_next = SCAN_W'(cur_idx);
                        end
                    end
                end else if (scan_end) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_key_next    = '0;
                        out_status_next = STATUS_FAIL;
                        state_next      = S_IDLE;
                    end
                end else if (map_word != '0) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_key_next    = KEY_OUT_W'(alloc_key);
                        out_status_next = STATUS_OK;
                        wr_en           = 1'b1;
                        wr_data         = map_word & ~(WORD_W'(1) << low_bit);
                        state_next      = S_IDLE;
                    end
                end else begin
                    // advance; read the next word unless the map end is reached
                    scan_word_next = scan_inc;
                    if (scan_inc != SCAN_W'(MAP_WORDS)) begin
                        rd_en   = 1'b1;
                        rd_addr = scan_inc[WORD_AW-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en) begin
            valid_next[cur_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            scan_word_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_word_reg <= scan_word_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        if (accept) begin
            act_reg    <= s_tuser[0];
            key_ok_reg <= (s_tdata < KEY_W'(KEY_LIMIT));
            slot_reg   <= s_tdata[SLOT_W+1:2];
        end
    end

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_word_reg <= SCAN_W'(MAP_WORDS))
        else $error("start word beyond map end");

    a_scan_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(scan_word_reg) |-> $past(state_reg == S_CHK))
        else $error("start word moved outside a check cycle");

    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> out_valid_reg)
        else $error("map write without a result beat");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == STATUS_FAIL |-> out_key_reg == '0)
        else $error("failed result carries a nonzero key");

endmodule
